>>> hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CfgIdxW = 8;

  // Item codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_RESP  = 1'b1;
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CFG_ALLOWED_LOW  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALLOWED_HIGH = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_MASK   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEAF_MASK    = 8'd3;

  // Reset values of the registers
  localparam logic [AddrW-1:0] ALLOWED_LOW_RST  = 64'h0;
  localparam logic [AddrW-1:0] ALLOWED_HIGH_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [AddrW-1:0] FRAME_MASK_RST   = 64'h000F_FFFF_FFFF_F000;

  // Fixed masks of the walk
  localparam logic [AddrW-1:0] GIG_FRAME_MASK   = 64'h000F_FFFF_C000_0000;
  localparam logic [AddrW-1:0] GIG_OFFSET_MASK  = 64'h0000_0000_3FFF_FFFF;
  localparam logic [AddrW-1:0] MEG_OFFSET_MASK  = 64'h0000_0000_001F_FFFF;
  localparam logic [AddrW-1:0] PAGE_OFFSET_MASK = 64'h0000_0000_0000_0FFF;
  localparam logic [AddrW-1:0] BASE_LOW_MASK    = 64'hFFFF_FFFF_FFFF_FFF0;
  localparam logic [AddrW-1:0] ENTRY_LAST_OFS   = 64'd7;

  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_PRESENT = 3'd1,
    ST_RANGE       = 3'd2,
    ST_STRAY       = 3'd3,
    ST_BUSY        = 3'd4
  } ptw_status_t;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] virt_addr;
    logic [AddrW-1:0] dir_base;
    logic [AddrW-1:0] read_data;
  } ptw_item_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] mem_addr;
    logic [AddrW-1:0] phys_addr;
    ptw_status_t      status;
  } ptw_result_t;

  typedef struct packed {
    logic             busy;
    logic [1:0]       walk_level;
    logic [AddrW-1:0] saved_vaddr;
  } ptw_state_t;

  typedef struct packed {
    logic [AddrW-1:0] allowed_low;
    logic [AddrW-1:0] allowed_high;
    logic [AddrW-1:0] table_frame_mask;
    logic [AddrW-1:0] leaf_frame_mask;
  } ptw_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptw_req_if.sv
// ----------------------------------------------------------------------------
// ptw_req_if
// Input channel: start items and memory read responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptw_req_if;
  import ptw_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [AddrW-1:0] virt_addr;
  logic [AddrW-1:0] dir_base;
  logic [AddrW-1:0] read_data;

  modport source (output valid, action, virt_addr, dir_base, read_data, input ready);
  modport sink   (input valid, action, virt_addr, dir_base, read_data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ptw_rsp_if.sv
// ----------------------------------------------------------------------------
// ptw_rsp_if
// Result channel: read requests and walk completions.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptw_rsp_if;
  import ptw_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [AddrW-1:0] mem_addr;
  logic [AddrW-1:0] phys_addr;
  logic [2:0]       status;

  modport source (output valid, kind, mem_addr, phys_addr, status, input ready);
  modport sink   (input valid, kind, mem_addr, phys_addr, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ptw_cfg_if.sv
// ----------------------------------------------------------------------------
// ptw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptw_cfg_if;
  import ptw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [AddrW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ptw_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptw_cfg_regs
// Window and frame mask registers, written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_cfg_regs (
  input  wire logic       clk,
  input  wire logic       rst,
  ptw_cfg_if.sink         cfg,
  output ptw_pkg::ptw_cfg_t regs
);
  import ptw_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.allowed_low      <= ALLOWED_LOW_RST;
      regs.allowed_high     <= ALLOWED_HIGH_RST;
      regs.table_frame_mask <= FRAME_MASK_RST;
      regs.leaf_frame_mask  <= FRAME_MASK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ALLOWED_LOW:  regs.allowed_low      <= cfg.data;
        CFG_ALLOWED_HIGH: regs.allowed_high     <= cfg.data;
        CFG_TABLE_MASK:   regs.table_frame_mask <= cfg.data;
        CFG_LEAF_MASK:    regs.leaf_frame_mask  <= cfg.data;
        default: ; // unknown index: ignored
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ptw_step.sv
// ----------------------------------------------------------------------------
// ptw_step
// One walk step: from an item and the walk state, the result and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_step (
  input  wire ptw_pkg::ptw_item_t  item,
  input  wire ptw_pkg::ptw_state_t state,
  input  wire ptw_pkg::ptw_cfg_t   regs,
  output ptw_pkg::ptw_result_t result,
  output ptw_pkg::ptw_state_t  state_next
);
  import ptw_pkg::*;

  logic [AddrW-1:0] va;
  logic [AddrW-1:0] entry;
  logic [AddrW-1:0] leaf_frame;
  logic [AddrW-1:0] req_addr;
  logic [AddrW-1:0] req_last;
  logic [AddrW-1:0] fin_phys;
  logic [1:0]       req_level;
  logic             do_req;
  logic             do_fin;
  logic             in_window;
  ptw_status_t      fin_st;

  // 8 * 9-bit index of the given level
  function automatic logic [AddrW-1:0] idx_ofs(input logic [AddrW-1:0] v,
                                               input logic [1:0] lvl);
    logic [8:0] idx;
    begin
      case (lvl)
        2'd0:    idx = v[47:39];
        2'd1:    idx = v[38:30];
        2'd2:    idx = v[29:21];
        default: idx = v[20:12];
      endcase
      idx_ofs = {{(AddrW-12){1'b0}}, idx, 3'b000};
    end
  endfunction

  assign va         = state.saved_vaddr;
  assign entry      = item.read_data;
  assign leaf_frame = entry & regs.leaf_frame_mask;

  // Decide on the step
  always_comb begin
    do_req    = 1'b0;
    do_fin    = 1'b0;
    req_addr  = '0;
    req_level = 2'd0;
    fin_phys  = '0;
    fin_st    = ST_OK;
    if (item.action == ACT_START) begin
      if (state.busy) begin
        fin_st = ST_BUSY;
      end else begin
        do_req   = 1'b1;
        req_addr = (item.dir_base & BASE_LOW_MASK) + idx_ofs(item.virt_addr, 2'd0);
      end
    end else if (!state.busy) begin
      fin_st = ST_STRAY;
    end else begin
      case (state.walk_level)
        2'd0: begin
          if (!entry[PRESENT_BIT]) begin
            do_fin = 1'b1;
            fin_st = ST_NOT_PRESENT;
          end else begin
            do_req    = 1'b1;
            req_level = 2'd1;
            req_addr  = (entry & regs.table_frame_mask) + idx_ofs(va, 2'd1);
          end
        end
        2'd1: begin
          if (!entry[PRESENT_BIT]) begin
            do_fin = 1'b1;
            fin_st = ST_NOT_PRESENT;
          end else if (entry[LARGE_BIT]) begin
            do_fin   = 1'b1;
            fin_phys = (entry & GIG_FRAME_MASK) + (va & GIG_OFFSET_MASK);
          end else begin
            do_req    = 1'b1;
            req_level = 2'd2;
            req_addr  = (entry & regs.table_frame_mask) + idx_ofs(va, 2'd2);
          end
        end
        2'd2: begin
          if (!entry[PRESENT_BIT]) begin
            do_fin = 1'b1;
            fin_st = ST_NOT_PRESENT;
          end else if (entry[LARGE_BIT]) begin
            do_fin   = 1'b1;
            fin_phys = (leaf_frame & ~MEG_OFFSET_MASK) + (va & MEG_OFFSET_MASK);
          end else begin
            do_req    = 1'b1;
            req_level = 2'd3;
            req_addr  = leaf_frame + idx_ofs(va, 2'd3);
          end
        end
        default: begin
          do_fin = 1'b1;
          if (leaf_frame == '0) begin
            fin_st = ST_NOT_PRESENT;
          end else begin
            fin_phys = leaf_frame + (va & PAGE_OFFSET_MASK);
          end
        end
      endcase
    end
  end

  // Both ends of the 8-byte entry must fall inside the window
  assign req_last  = req_addr + ENTRY_LAST_OFS;
  assign in_window = (req_addr >= regs.allowed_low) && (req_addr <= regs.allowed_high) &&
                     (req_last >= regs.allowed_low) && (req_last <= regs.allowed_high);

  // Result and next state
  always_comb begin
    state_next       = state;
    result.kind      = KIND_DONE;
    result.mem_addr  = '0;
    result.phys_addr = '0;
    result.status    = fin_st;
    if (item.action == ACT_START && !state.busy) begin
      state_next.saved_vaddr = item.virt_addr;
    end
    if (do_req) begin
      if (in_window) begin
        state_next.busy       = 1'b1;
        state_next.walk_level = req_level;
        result.kind           = KIND_READ;
        result.mem_addr       = req_addr;
        result.status         = ST_OK;
      end else begin
        state_next.busy       = 1'b0;
        state_next.walk_level = 2'd0;
        result.status         = ST_RANGE;
      end
    end else if (do_fin) begin
      state_next.busy       = 1'b0;
      state_next.walk_level = 2'd0;
      result.phys_addr      = (fin_st == ST_OK) ? fin_phys : '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/four_level_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Four-level page table walker: start items and read responses in, one
// read request or completion out for each item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | action, virt_addr, dir_base, read_data
//  rsp     | out | valid/ready | kind, mem_addr, phys_addr, status
//  cfg     | in  | valid/ready | index, data (ready always high)
//
// Each item is latched in an input register and resolved from there into the
// result register; while the result channel is not stalled, one item can be
// taken every cycle. Walk state is updated as an item moves into the result
// register. A stalled result holds both registers; req.ready drops only when
// the input register is full and cannot move on. Reset (rst) clears the
// valid flags, the walk state and the registers to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_core (
  input  wire logic clk,
  input  wire logic rst,
  ptw_req_if.sink   req,
  ptw_rsp_if.source rsp,
  ptw_cfg_if.sink   cfg
);
  import ptw_pkg::*;

  ptw_cfg_t    regs;
  ptw_item_t   in_item;
  logic        in_valid;
  ptw_state_t  state;
  ptw_state_t  state_next;
  ptw_result_t result_next;
  ptw_result_t out_item;
  logic        out_valid;
  logic        advance;

  ptw_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ptw_step u_step (
    .item       (in_item),
    .state      (state),
    .regs       (regs),
    .result     (result_next),
    .state_next (state_next)
  );

  // Move the input item on when the result register is free or being taken
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      in_item.action    <= req.action;
      in_item.virt_addr <= req.virt_addr;
      in_item.dir_base  <= req.dir_base;
      in_item.read_data <= req.read_data;
    end
  end

  // Walk state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_item <= result_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.kind      = out_item.kind;
  assign rsp.mem_addr  = out_item.mem_addr;
  assign rsp.phys_addr = out_item.phys_addr;
  assign rsp.status    = out_item.status;

endmodule

`default_nettype wire

>>> test/four_level_page_table_walker_core_tb.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core_tb
// Self-checking bench for the four-level page table walker. A short table
// of directed items runs first: reset values, address wrap, large pages,
// faults, stray and busy items and the entry window. It is followed by
// phases of random walks, each under its own register setting. Every item
// accepted on the request channel is run through a local walk predictor.
// Every item on the result channel is compared field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_core_tb;
  import ptw_pkg::*;

  localparam int unsigned LIMIT_CYC  = 100000;
  localparam int unsigned SETTLE_CYC = 4;
  localparam int unsigned NUM_PHASES = 7;
  localparam logic [AddrW-1:0] ONES  = '1;

  typedef struct {
    ptw_item_t   item;
    bit          fixed;
    ptw_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptw_req_if req_ch ();
  ptw_rsp_if rsp_ch ();
  ptw_cfg_if cfg_ch ();

  four_level_page_table_walker_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  // Predictor state and register copy
  ptw_state_t  walk_st;
  ptw_cfg_t    cfg_mirror;
  ptw_result_t walk_exp_q[$];
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet     = 1'b0;

  // Idle cycles before an item on either side
  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic logic [AddrW-1:0] entry_ofs(logic [AddrW-1:0] va, int unsigned lvl);
    return ((va >> (39 - 9 * lvl)) & 64'h1FF) << 3;
  endfunction

  function automatic ptw_result_t end_walk(logic [AddrW-1:0] phys, ptw_status_t st);
    ptw_result_t r;
    walk_st.busy       = 1'b0;
    walk_st.walk_level = 2'd0;
    r.kind      = KIND_DONE;
    r.mem_addr  = '0;
    r.phys_addr = (st == ST_OK) ? phys : '0;
    r.status    = st;
    return r;
  endfunction

  function automatic ptw_result_t issue_read(logic [AddrW-1:0] addr, logic [1:0] lvl);
    ptw_result_t r;
    logic [AddrW-1:0] last;
    last = addr + ENTRY_LAST_OFS;
    if (!(addr >= cfg_mirror.allowed_low && addr <= cfg_mirror.allowed_high &&
          last >= cfg_mirror.allowed_low && last <= cfg_mirror.allowed_high))
      return end_walk('0, ST_RANGE);
    walk_st.busy       = 1'b1;
    walk_st.walk_level = lvl;
    r.kind      = KIND_READ;
    r.mem_addr  = addr;
    r.phys_addr = '0;
    r.status    = ST_OK;
    return r;
  endfunction

  // Advances the walk by one accepted item and returns what it answers
  function automatic ptw_result_t walk_predict(ptw_item_t it);
    ptw_result_t r;
    logic [AddrW-1:0] e, va, tm, lm, frame;
    e  = it.read_data;
    va = walk_st.saved_vaddr;
    tm = cfg_mirror.table_frame_mask;
    lm = cfg_mirror.leaf_frame_mask;
    r.kind      = KIND_DONE;
    r.mem_addr  = '0;
    r.phys_addr = '0;
    if (it.action == ACT_START) begin
      if (walk_st.busy) begin
        r.status = ST_BUSY;
        return r;
      end
      walk_st.saved_vaddr = it.virt_addr;
      return issue_read((it.dir_base & BASE_LOW_MASK) + entry_ofs(it.virt_addr, 0), 2'd0);
    end
    if (!walk_st.busy) begin
      r.status = ST_STRAY;
      return r;
    end
    case (walk_st.walk_level)
      2'd0: begin
        if (!e[PRESENT_BIT]) r = end_walk('0, ST_NOT_PRESENT);
        else r = issue_read((e & tm) + entry_ofs(va, 1), 2'd1);
      end
      2'd1: begin
        if (!e[PRESENT_BIT]) r = end_walk('0, ST_NOT_PRESENT);
        else if (e[LARGE_BIT])
          r = end_walk((e & GIG_FRAME_MASK) + (va & GIG_OFFSET_MASK), ST_OK);
        else r = issue_read((e & tm) + entry_ofs(va, 2), 2'd2);
      end
      2'd2: begin
        if (!e[PRESENT_BIT]) r = end_walk('0, ST_NOT_PRESENT);
        else if (e[LARGE_BIT])
          r = end_walk((e & lm & ~MEG_OFFSET_MASK) + (va & MEG_OFFSET_MASK), ST_OK);
        else r = issue_read((e & lm) + entry_ofs(va, 3), 2'd3);
      end
      default: begin
        // leaf: present bit is not looked at, a zero frame faults instead
        frame = e & lm;
        if (frame == '0) r = end_walk('0, ST_NOT_PRESENT);
        else r = end_walk(frame + (va & PAGE_OFFSET_MASK), ST_OK);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  // Address inside the window, near one of its edges, or anywhere at all
  function automatic logic [AddrW-1:0] pick_addr();
    logic [AddrW-1:0] lo, hi, span;
    lo   = cfg_mirror.allowed_low;
    hi   = cfg_mirror.allowed_high;
    span = hi - lo;
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return lo + $urandom_range(0, 'h3FFF);
      2: return hi - $urandom_range(0, 'h3FFF);
      default: begin
        if (span == ONES) return rand64();
        return lo + (rand64() % (span + 64'd1));
      end
    endcase
  endfunction

  // Mostly the item that the current walk is waiting for, with some noise
  function automatic ptw_item_t gen_item();
    ptw_item_t it;
    logic [AddrW-1:0] e;
    it.virt_addr = rand64();
    it.dir_base  = rand64();
    it.read_data = rand64();
    if ($urandom_range(0, 9) == 0) begin
      it.action = 1'($urandom_range(0, 1));
    end else if (!walk_st.busy || $urandom_range(0, 19) == 0) begin
      it.action   = ACT_START;
      it.dir_base = pick_addr();
    end else begin
      it.action = ACT_RESP;
      e = pick_addr() & ~PAGE_OFFSET_MASK;
      if ($urandom_range(0, 1) == 1) e[63:52] = 12'($urandom());
      e[11:0]         = 12'($urandom());
      e[PRESENT_BIT]  = ($urandom_range(0, 15) != 0);
      e[LARGE_BIT]    = (walk_st.walk_level inside {2'd1, 2'd2}) ?
                        ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
      if (walk_st.walk_level == 2'd3 && $urandom_range(0, 7) == 0)
        e = e & ~cfg_mirror.leaf_frame_mask;
      it.read_data = e;
    end
    return it;
  endfunction

  function automatic dir_row_t row_pred(logic act, logic [AddrW-1:0] va,
                                        logic [AddrW-1:0] base, logic [AddrW-1:0] data);
    dir_row_t row;
    row.item  = '{action: act, virt_addr: va, dir_base: base, read_data: data};
    row.fixed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic dir_row_t row_fix(logic act, logic [AddrW-1:0] va,
                                       logic [AddrW-1:0] base, logic [AddrW-1:0] data,
                                       logic kind, logic [AddrW-1:0] addr, ptw_status_t st);
    dir_row_t row;
    row = row_pred(act, va, base, data);
    row.fixed         = 1'b1;
    row.res.kind      = kind;
    row.res.mem_addr  = addr;
    row.res.phys_addr = '0;
    row.res.status    = st;
    return row;
  endfunction

  // One item on the request channel; its expectation is queued on acceptance
  task automatic send_item(ptw_item_t it, bit fixed, ptw_result_t fix_res);
    int unsigned gap;
    ptw_result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= it.action;
    req_ch.virt_addr <= it.virt_addr;
    req_ch.dir_base  <= it.dir_base;
    req_ch.read_data <= it.read_data;
    do @(posedge clk); while (!req_ch.ready);
    r = walk_predict(it);
    walk_exp_q.push_back(fixed ? fix_res : r);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ALLOWED_LOW:  cfg_mirror.allowed_low      = val;
      CFG_ALLOWED_HIGH: cfg_mirror.allowed_high     = val;
      CFG_TABLE_MASK:   cfg_mirror.table_frame_mask = val;
      CFG_LEAF_MASK:    cfg_mirror.leaf_frame_mask  = val;
      default: ;
    endcase
  endtask

  // Let the walker drain, then rewrite all four registers
  task automatic load_regs(logic [AddrW-1:0] lo, logic [AddrW-1:0] hi,
                           logic [AddrW-1:0] tm, logic [AddrW-1:0] lm);
    req_ch.valid <= 1'b0;
    while (walk_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(CFG_ALLOWED_LOW, lo);
    write_reg(CFG_ALLOWED_HIGH, hi);
    write_reg(CFG_TABLE_MASK, tm);
    write_reg(CFG_LEAF_MASK, lm);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    int unsigned n;
    forever begin
      n = draw_gap();
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rst || !rsp_ch.valid);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    ptw_result_t ex;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (walk_exp_q.size() == 0) begin
        $error("result with nothing expected: kind %0d addr %h phys %h status %0d",
               rsp_ch.kind, rsp_ch.mem_addr, rsp_ch.phys_addr, rsp_ch.status);
        fail_cnt++;
      end else begin
        ex = walk_exp_q.pop_front();
        if (rsp_ch.kind !== ex.kind) begin
          $error("kind: expected %0d, got %0d", ex.kind, rsp_ch.kind);
          fail_cnt++;
        end
        if (rsp_ch.mem_addr !== ex.mem_addr) begin
          $error("mem_addr: expected %h, got %h", ex.mem_addr, rsp_ch.mem_addr);
          fail_cnt++;
        end
        if (rsp_ch.phys_addr !== ex.phys_addr) begin
          $error("phys_addr: expected %h, got %h", ex.phys_addr, rsp_ch.phys_addr);
          fail_cnt++;
        end
        if (rsp_ch.status !== ex.status) begin
          $error("status: expected %0d, got %0d", ex.status, rsp_ch.status);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYC) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    dir_row_t    dir_rows[$];
    int unsigned win_row;
    int unsigned ph_items;
    logic [AddrW-1:0] lo, hi, tm, lm;

    req_ch.valid     <= 1'b0;
    req_ch.action    <= ACT_START;
    req_ch.virt_addr <= '0;
    req_ch.dir_base  <= '0;
    req_ch.read_data <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_ALLOWED_LOW;
    cfg_ch.data      <= '0;

    walk_st    = '0;
    cfg_mirror = '{allowed_low: ALLOWED_LOW_RST, allowed_high: ALLOWED_HIGH_RST,
                   table_frame_mask: FRAME_MASK_RST, leaf_frame_mask: FRAME_MASK_RST};

    // stray response, first read, busy start, not present at the top level
    dir_rows.push_back(row_fix(ACT_RESP, 0, 0, ONES, KIND_DONE, 0, ST_STRAY));
    dir_rows.push_back(row_fix(ACT_START, 0, 64'h1000, 0, KIND_READ, 64'h1000, ST_OK));
    dir_rows.push_back(row_fix(ACT_START, ONES, ONES, 0, KIND_DONE, 0, ST_BUSY));
    dir_rows.push_back(row_fix(ACT_RESP, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE,
                               KIND_DONE, 0, ST_NOT_PRESENT));
    // all-ones address and base: entry address wraps, then a 1 GB page
    dir_rows.push_back(row_pred(ACT_START, ONES, ONES, 0));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, ONES));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h0000_0040_0000_0081));
    // low base bits ignored, 2 MB page
    dir_rows.push_back(row_pred(ACT_START, 64'h0000_7FFF_FFFF_FFFF, 64'h200F, 0));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h3003));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h4003));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h0000_0000_4060_0081));
    // full walk ending on a leaf with a zero frame
    dir_rows.push_back(row_pred(ACT_START, 64'h0000_1234_5678_9ABC, 64'h10000, 0));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h11001));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h12001));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h13001));
    dir_rows.push_back(row_fix(ACT_RESP, 0, 0, 64'hFFF0_0000_0000_0FFF,
                               KIND_DONE, 0, ST_NOT_PRESENT));
    // full walk to a 4 KB leaf whose present bit is clear
    dir_rows.push_back(row_pred(ACT_START, 64'hFFFF_8000_0000_1234, 64'h20000, 0));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h21001));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h22001));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h23001));
    dir_rows.push_back(row_pred(ACT_RESP, 0, 0, 64'h0000_0000_0ABC_D000));
    // entry window 0x1000..0x1FFB from here on
    win_row = dir_rows.size();
    dir_rows.push_back(row_fix(ACT_START, 0, 64'h1FF0, 0, KIND_READ, 64'h1FF0, ST_OK));
    dir_rows.push_back(row_fix(ACT_RESP, 0, 0, 64'h2001, KIND_DONE, 0, ST_RANGE));
    // last byte of the entry past the top of the window
    dir_rows.push_back(row_fix(ACT_START, 64'h0000_0080_0000_0000, 64'h1FF0, 0,
                               KIND_DONE, 0, ST_RANGE));
    dir_rows.push_back(row_fix(ACT_START, 0, 64'h0FF0, 0, KIND_DONE, 0, ST_RANGE));

    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == win_row)
        load_regs(64'h1000, 64'h1FFB, FRAME_MASK_RST, FRAME_MASK_RST);
      send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);
    end

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      ph_items = 70;
      tm = FRAME_MASK_RST;
      lm = FRAME_MASK_RST;
      case (p)
        0: begin
          lo = 64'h0010_0000;
          hi = 64'h7FFF_FFFF;
        end
        1: begin
          // widest masks, full window, no idling
          lo = '0;
          hi = ONES;
          tm = ONES;
          lm = ONES;
        end
        2: begin
          // window of one byte: every entry faults
          lo = ONES;
          hi = ONES;
          ph_items = 20;
        end
        3: begin
          // zero masks: tables at the bottom of memory, 4 KB leaves never map
          lo = '0;
          hi = 64'h7FFF;
          tm = '0;
          lm = '0;
        end
        4: begin
          lo = rand64() >> $urandom_range(1, 40);
          hi = lo + (rand64() >> $urandom_range(20, 50));
          tm = rand64();
          lm = rand64();
        end
        5: begin
          // window at the top of the address space, entries wrap past it
          lo = 64'hFFFF_FFFF_FFFF_0000;
          hi = ONES;
          tm = ONES;
        end
        default: begin
          lo = ALLOWED_LOW_RST;
          hi = ALLOWED_HIGH_RST;
        end
      endcase
      load_regs(lo, hi, tm, lm);
      quiet = (p == 1);
      for (int k = 0; k < ph_items; k++)
        send_item(gen_item(), 1'b0, '0);
    end
    quiet = 1'b0;

    // drain and let the pipeline empty
    req_ch.valid <= 1'b0;
    while (walk_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC * 4) @(posedge clk);

    if (fail_cnt == 0 && walk_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> four_level_page_table_walker_core.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_req_if.sv
hw/rtl/ptw_rsp_if.sv
hw/rtl/ptw_cfg_if.sv
hw/rtl/ptw_cfg_regs.sv
hw/rtl/ptw_step.sv
hw/rtl/four_level_page_table_walker_core.sv
test/four_level_page_table_walker_core_tb.sv
